// File: rtl/qdbc_pkg.sv
// Shared types and constants of the quadrant dark blob centroid block.
package qdbc_pkg;

    localparam int SUM_W      = 32;
    localparam int CNT_W      = 21;
    localparam int CEN_W      = 11;
    localparam int QUAD_W     = 2;
    localparam int DOTS_W     = 3;
    localparam int THR_W      = 8;
    localparam int DIMREG_W   = 12;
    localparam int CFG_W      = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int NQUAD      = 4;
    localparam int FIFO_DEPTH = 2;

    localparam logic [CNT_W-1:0]    COUNT_MAX       = '1;
    localparam logic [THR_W-1:0]    RST_THRESHOLD   = 8'd60;
    localparam logic [CNT_W-1:0]    RST_MIN_PIXELS  = 21'd20;
    localparam logic [DIMREG_W-1:0] RST_WIDTH       = 12'd320;
    localparam logic [DIMREG_W-1:0] RST_HEIGHT      = 12'd240;
    localparam logic [QUAD_W-1:0]   QUAD_LAST       = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD  = 2'd0,
        CFG_MIN_PIXELS = 2'd1,
        CFG_WIDTH      = 2'd2,
        CFG_HEIGHT     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [THR_W-1:0]    dark_level;
        logic [CNT_W-1:0]    min_blob_pixels;
        logic [DIMREG_W-1:0] image_width;
        logic [DIMREG_W-1:0] image_height;
    } t_cfg;

    typedef struct packed {
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [CNT_W-1:0] count;
    } t_quad_acc;

    typedef t_quad_acc [NQUAD-1:0] t_frame_rec;

endpackage

// File: rtl/qdbc_if.sv
// Pixel and result channel interfaces of the quadrant dark blob centroid block.
interface qdbc_pix_if #(parameter int CHANNEL_BITS = 8);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface qdbc_res_if;
    import qdbc_pkg::*;
    logic              valid;
    logic              ready;
    logic [QUAD_W-1:0] quadrant;
    logic              dot_found;
    logic [CEN_W-1:0]  centroid_x;
    logic [CEN_W-1:0]  centroid_y;
    logic [DOTS_W-1:0] dots_so_far;
    logic              last_result;

    modport source (output valid, output quadrant, output dot_found, output centroid_x,
                    output centroid_y, output dots_so_far, output last_result, input ready);
    modport sink   (input valid, input quadrant, input dot_found, input centroid_x,
                    input centroid_y, input dots_so_far, input last_result, output ready);
endinterface

// File: rtl/qdbc_front.sv
// Front part: pixel position tracking, dark classification and quadrant accumulation.
module qdbc_front #(
    parameter int MAX_DIM      = 2048,
    parameter int CHANNEL_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qdbc_pkg::t_cfg      i_cfg,
    qdbc_pix_if.sink            i_pix,
    input  logic                i_fifo_full,
    output logic                o_push,
    output qdbc_pkg::t_frame_rec o_rec
);
    import qdbc_pkg::*;

    localparam int POS_W = $clog2(MAX_DIM);
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CLP_W = (DIM_W > DIMREG_W) ? DIM_W : DIMREG_W;
    localparam int CMP_W = (CHANNEL_BITS > THR_W) ? CHANNEL_BITS : THR_W;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIMREG_W-1:0] v);
        logic [CLP_W-1:0] ve;
        ve = CLP_W'(v);
        if (ve < CLP_W'(2)) begin
            clamp_dim = DIM_W'(2);
        end else if (ve > CLP_W'(MAX_DIM)) begin
            clamp_dim = DIM_W'(MAX_DIM);
        end else begin
            clamp_dim = DIM_W'(ve);
        end
    endfunction

    logic [POS_W-1:0]  r_col;
    logic [POS_W-1:0]  r_row;
    t_frame_rec        r_acc;
    t_frame_rec        n_acc;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [QUAD_W-1:0] q;
    logic [CMP_W-1:0]  thr;
    logic              dark;
    logic              accept;
    logic              row_end;
    logic              frame_end;

    assign w   = clamp_dim(i_cfg.image_width);
    assign h   = clamp_dim(i_cfg.image_height);
    assign thr = CMP_W'(i_cfg.dark_level);

    assign i_pix.ready = !i_fifo_full;
    assign accept      = i_pix.valid && !i_fifo_full;

    assign q[0] = DIM_W'(r_col) >= (w >> 1);
    assign q[1] = DIM_W'(r_row) >= (h >> 1);

    assign dark = (CMP_W'(i_pix.red) < thr) && (CMP_W'(i_pix.green) < thr)
               && (CMP_W'(i_pix.blue) < thr);

    assign row_end   = (DIM_W'(r_col) + DIM_W'(1)) >= w;
    assign frame_end = row_end && ((DIM_W'(r_row) + DIM_W'(1)) >= h);

    always_comb begin
        n_acc = r_acc;
        if (dark) begin
            n_acc[q].sum_x = r_acc[q].sum_x + SUM_W'(r_col);
            n_acc[q].sum_y = r_acc[q].sum_y + SUM_W'(r_row);
            if (r_acc[q].count != COUNT_MAX) begin
                n_acc[q].count = r_acc[q].count + CNT_W'(1);
            end
        end
    end

    assign o_push = accept && frame_end;
    assign o_rec  = n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_acc <= '0;
        end else if (accept) begin
            r_acc <= frame_end ? '0 : n_acc;
            if (!row_end) begin
                r_col <= r_col + POS_W'(1);
            end else begin
                r_col <= '0;
                r_row <= frame_end ? '0 : r_row + POS_W'(1);
            end
        end
    end

endmodule

// File: rtl/qdbc_fifo.sv
// Short queue of finished frame accumulator records between front and back.
module qdbc_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  qdbc_pkg::t_frame_rec i_rec,
    output logic                 o_full,
    input  logic                 i_pop,
    output qdbc_pkg::t_frame_rec o_rec,
    output logic                 o_empty
);
    import qdbc_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_QW = $clog2(FIFO_DEPTH + 1);

    t_frame_rec        r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_QW-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_cnt == CNT_QW'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rec   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_QW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNT_QW'(1);
            end
        end
    end

endmodule

// File: rtl/qdbc_back.sv
// Back part: per-quadrant centroid division and result sequencing.
module qdbc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [20:0]          i_min_blob_pixels,
    input  qdbc_pkg::t_frame_rec i_rec,
    input  logic                 i_fifo_empty,
    output logic                 o_pop,
    qdbc_res_if.source           o_res
);
    import qdbc_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIVX = 4'b0010,
        S_DIVY = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state            r_state;
    logic [QUAD_W-1:0] r_k;
    logic [SUM_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_rem;
    logic [CEN_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_step;
    logic [CEN_W-1:0]  r_cx;
    logic [CEN_W-1:0]  r_cy;
    logic [DOTS_W-1:0] r_found;

    logic              r_out_valid;
    logic [QUAD_W-1:0] r_out_quad;
    logic              r_out_found;
    logic [CEN_W-1:0]  r_out_cx;
    logic [CEN_W-1:0]  r_out_cy;
    logic [DOTS_W-1:0] r_out_dots;
    logic              r_out_last;

    t_quad_acc         cur;
    t_quad_acc         st_acc;
    logic [QUAD_W-1:0] st_k;
    logic              st_ok;
    logic              cur_ok;
    logic              start_q;
    logic              out_free;
    logic              div_last;
    logic [CNT_W:0]    rem_sh;
    logic              ge;
    logic [CNT_W-1:0]  rem_nx;
    logic [CEN_W-1:0]  quo_nx;
    logic [DOTS_W-1:0] dots_nx;

    function automatic logic acc_ok(input t_quad_acc a, input logic [CNT_W-1:0] mn);
        acc_ok = (a.count != '0) && (a.count >= mn);
    endfunction

    assign cur      = i_rec[r_k];
    assign cur_ok   = acc_ok(cur, i_min_blob_pixels);
    assign out_free = !r_out_valid || o_res.ready;

    // Quadrant to open next: the first one of a queued frame, or the one after r_k.
    assign st_k    = (r_state == S_IDLE) ? '0 : r_k + QUAD_W'(1);
    assign st_acc  = i_rec[st_k];
    assign st_ok   = acc_ok(st_acc, i_min_blob_pixels);
    assign start_q = ((r_state == S_IDLE) && !i_fifo_empty)
                  || ((r_state == S_EMIT) && out_free && (r_k != QUAD_LAST));
    assign o_pop   = (r_state == S_EMIT) && out_free && (r_k == QUAD_LAST);

    // One restoring division step.
    assign rem_sh   = {r_rem, r_dvd[SUM_W-1]};
    assign ge       = rem_sh >= {1'b0, cur.count};
    assign rem_nx   = ge ? CNT_W'(rem_sh - {1'b0, cur.count}) : CNT_W'(rem_sh);
    assign quo_nx   = {r_quo[CEN_W-2:0], ge};
    assign div_last = (r_step == STEP_W'(SUM_W - 1));
    assign dots_nx  = r_found + DOTS_W'(cur_ok);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_found     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                end
                S_DIVX, S_DIVY: begin
                    r_rem  <= rem_nx;
                    r_dvd  <= r_dvd << 1;
                    r_quo  <= quo_nx;
                    r_step <= r_step + STEP_W'(1);
                    if (div_last) begin
                        if (r_state == S_DIVX) begin
                            r_cx    <= quo_nx;
                            r_dvd   <= cur.sum_y;
                            r_rem   <= '0;
                            r_step  <= '0;
                            r_state <= S_DIVY;
                        end else begin
                            r_cy    <= quo_nx;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_quad  <= r_k;
                        r_out_found <= cur_ok;
                        r_out_cx    <= r_cx;
                        r_out_cy    <= r_cy;
                        r_out_dots  <= dots_nx;
                        r_out_last  <= (r_k == QUAD_LAST);
                        if (r_k == QUAD_LAST) begin
                            r_found <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_found <= dots_nx;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (start_q) begin
                r_k <= st_k;
                if (st_ok) begin
                    r_dvd   <= st_acc.sum_x;
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= S_DIVX;
                end else begin
                    r_cx    <= '0;
                    r_cy    <= '0;
                    r_state <= S_EMIT;
                end
            end
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.quadrant    = r_out_quad;
    assign o_res.dot_found   = r_out_found;
    assign o_res.centroid_x  = r_out_cx;
    assign o_res.centroid_y  = r_out_cy;
    assign o_res.dots_so_far = r_out_dots;
    assign o_res.last_result = r_out_last;

endmodule

// File: rtl/quadrant_dark_blob_centroid.sv
// Top level of the quadrant dark blob centroid block: configuration, front, queue and back.
//
// The block takes one RGB pixel per request in raster order, one request per clock cycle,
// and counts columns and rows itself against the configured frame size (clamped to
// 2..MAX_DIM). The frame is cut at half width and half height into four quadrants; a pixel
// whose three channels all lie below the dark threshold adds its column, its row and one
// to the sums of its quadrant. When the last pixel of a frame is taken, the sums move into
// a two-entry queue and the front carries straight on with the next frame. The back part
// then sends four result requests, top-left, top-right, bottom-left, bottom-right, each
// with the found flag, the floor centroid (zero when not found) and the running number of
// dots; the last one is flagged. Centroids come from a restoring divider that yields one
// quotient bit per cycle; a found quadrant divides its column sum and then its row sum
// before it issues its result, and a quadrant that is not found skips the division.
// Pixels keep flowing at one per cycle as long as the queue has room; a run of short frames
// back to back, or a result port held off, fills the queue and stops pixel intake
// until an entry frees. Configuration should be written only while the block is idle.
// The dark pixel counts saturate at 2^21-1 and the sums wrap at 32 bits.
module quadrant_dark_blob_centroid #(
    parameter int MAX_DIM      = 2048,
    parameter int CHANNEL_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [20:0] i_cfg_data,
    qdbc_pix_if.sink    i_pix,
    qdbc_res_if.source  o_res
);
    import qdbc_pkg::*;

    t_cfg       r_cfg;
    t_frame_rec front_rec;
    t_frame_rec queue_rec;
    logic       push;
    logic       pop;
    logic       fifo_full;
    logic       fifo_empty;

    // Register writes land at once; there is no read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dark_level      <= RST_THRESHOLD;
            r_cfg.min_blob_pixels <= RST_MIN_PIXELS;
            r_cfg.image_width     <= RST_WIDTH;
            r_cfg.image_height    <= RST_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_THRESHOLD:  r_cfg.dark_level      <= i_cfg_data[THR_W-1:0];
                CFG_MIN_PIXELS: r_cfg.min_blob_pixels <= i_cfg_data[CNT_W-1:0];
                CFG_WIDTH:      r_cfg.image_width     <= i_cfg_data[DIMREG_W-1:0];
                CFG_HEIGHT:     r_cfg.image_height    <= i_cfg_data[DIMREG_W-1:0];
                default: ;
            endcase
        end
    end

    // The front classifies and accumulates pixels and hands over one record per frame.
    qdbc_front #(
        .MAX_DIM      (MAX_DIM),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pix       (i_pix),
        .i_fifo_full (fifo_full),
        .o_push      (push),
        .o_rec       (front_rec)
    );

    // The queue lets the front run into the next frame while the back divides.
    qdbc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .o_full  (fifo_full),
        .i_pop   (pop),
        .o_rec   (queue_rec),
        .o_empty (fifo_empty)
    );

    // The back turns each queued record into four result requests.
    qdbc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_min_blob_pixels (r_cfg.min_blob_pixels),
        .i_rec             (queue_rec),
        .i_fifo_empty      (fifo_empty),
        .o_pop             (pop),
        .o_res             (o_res)
    );

    // A frame record is never pushed into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && fifo_full))
        else $error("frame record pushed into a full queue");

    // The queue is never popped while empty.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && fifo_empty))
        else $error("queue popped while empty");

    // Only the bottom-right result closes a frame, and the queue entry leaves with it.
    a_last_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.last_result == (o_res.quadrant == QUAD_LAST)))
        else $error("last flag does not match the bottom-right quadrant");

    // A quadrant that is not found reports a zero centroid, and the dot tally stays
    // within the number of quadrants issued before it.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.dot_found) |->
            ((o_res.centroid_x == '0) && (o_res.centroid_y == '0)
             && ({1'b0, o_res.dots_so_far} <= {2'b00, o_res.quadrant}
                 + {3'b000, 1'b1} - {3'b000, 1'b1})))
        else $error("result not found but carries a centroid or too many dots");

endmodule

// File: test/tb_quadrant_dark_blob_centroid.sv
// Self-checking testbench for the quadrant dark blob centroid block.
`timescale 1ns / 100ps

module tb_quadrant_dark_blob_centroid;
    import qdbc_pkg::*;

    // Sizes of the block as built here.
    localparam int PIX_BITS = 8;
    localparam int MAX_DIM  = 2048;

    // This many quiet cycles after the last expected result is ample for the back part to
    // finish before a register write or the end of the run.
    localparam int DRAIN_CYCLES = 400;
    // The watchdog ends the run when no request of either channel completes for this long.
    localparam int STALL_LIMIT  = 20000;
    // The random part runs until both of these have been reached.
    localparam int RANDOM_PIXELS = 180;
    localparam int MIN_FRAMES    = 6;
    // Mismatch lines beyond this number are counted but not printed.
    localparam int MAX_REPORTS   = 40;

    typedef struct packed {
        logic [PIX_BITS-1:0] red;
        logic [PIX_BITS-1:0] green;
        logic [PIX_BITS-1:0] blue;
    } t_rgb;

    // One quadrant report, field for field as the result channel carries it.
    typedef struct packed {
        logic [QUAD_W-1:0] quadrant;
        logic              dot_found;
        logic [CEN_W-1:0]  centroid_x;
        logic [CEN_W-1:0]  centroid_y;
        logic [DOTS_W-1:0] dots_so_far;
        logic              last_result;
    } t_blob_report;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    t_cfg_idx         cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    qdbc_pix_if #(.CHANNEL_BITS(PIX_BITS)) pix ();
    qdbc_res_if res ();

    quadrant_dark_blob_centroid #(
        .MAX_DIM      (MAX_DIM),
        .CHANNEL_BITS (PIX_BITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix),
        .o_res      (res)
    );

    // Our own copy of the configuration registers, updated at the edge that writes them.
    logic [THR_W-1:0]    thr_cfg;
    logic [CNT_W-1:0]    min_cfg;
    logic [DIMREG_W-1:0] width_cfg;
    logic [DIMREG_W-1:0] height_cfg;

    // Our own copy of the raster position and of the per-quadrant accumulators.
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [SUM_W-1:0] col_sum  [NQUAD];
    logic [SUM_W-1:0] row_sum  [NQUAD];
    logic [CNT_W-1:0] dark_cnt [NQUAD];

    // Quadrant reports that the accepted pixels call for, oldest first.
    t_blob_report pending_blobs[$];

    int errors;
    int pixels_sent;
    int frames_closed;
    int blobs_checked;
    int dots_seen;
    int src_idle_pct;
    int snk_idle_pct;
    int stall_cycles;

    // Clock with a 10 ns period.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The result side takes requests at random, at the rate that the current phase asks.
    always @(posedge i_clk) begin
        res.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Frame size as the block uses it: the register value saturated into 2..MAX_DIM.
    function automatic int unsigned clamp_dim(input logic [DIMREG_W-1:0] v);
        if (v < 2) return 2;
        if (v > MAX_DIM) return MAX_DIM;
        return 32'(v);
    endfunction

    // Takes one accepted pixel into the accumulators and, on the last pixel of a frame,
    // queues the four quadrant reports and clears the accumulators.
    function automatic void account_pixel(input t_rgb p);
        int unsigned       w;
        int unsigned       h;
        logic [QUAD_W-1:0] q;
        int unsigned       found;
        int                k;
        logic              ok;
        t_blob_report      rep;

        w = clamp_dim(width_cfg);
        h = clamp_dim(height_cfg);
        q = {(row_pos >= h / 2), (col_pos >= w / 2)};

        // Dark only when all three channels lie strictly below the threshold.
        if (p.red < thr_cfg && p.green < thr_cfg && p.blue < thr_cfg) begin
            col_sum[q] += col_pos;
            row_sum[q] += row_pos;
            if (dark_cnt[q] != COUNT_MAX) dark_cnt[q] += CNT_W'(1);
        end

        // A position already at or past a size that was made smaller mid-frame ends the
        // row (or the frame) at once, hence the comparison rather than an equality.
        if (col_pos + 1 < w) begin
            col_pos++;
            return;
        end
        col_pos = 0;
        if (row_pos + 1 < h) begin
            row_pos++;
            return;
        end
        row_pos = 0;

        found = 0;
        for (k = 0; k < NQUAD; k++) begin
            // An empty quadrant never counts as found, even with a minimum of zero.
            ok = (dark_cnt[k] != 0) && (dark_cnt[k] >= min_cfg);
            rep.quadrant    = k[QUAD_W-1:0];
            rep.dot_found   = ok;
            rep.centroid_x  = '0;
            rep.centroid_y  = '0;
            if (ok) begin
                rep.centroid_x = CEN_W'((col_sum[k] / SUM_W'(dark_cnt[k])) & 32'h7FF);
                rep.centroid_y = CEN_W'((row_sum[k] / SUM_W'(dark_cnt[k])) & 32'h7FF);
                found++;
            end
            rep.dots_so_far = found[DOTS_W-1:0];
            rep.last_result = (k[QUAD_W-1:0] == QUAD_LAST);
            pending_blobs.push_back(rep);
            col_sum[k]  = '0;
            row_sum[k]  = '0;
            dark_cnt[k] = '0;
        end
        frames_closed++;
    endfunction

    // Builds a pixel that is dark with the given likelihood. Dark pixels sometimes sit just
    // below the threshold; the others mostly carry one channel at or above it.
    function automatic t_rgb make_pixel(input int dark_pct);
        t_rgb                p;
        logic [PIX_BITS-1:0] lit;

        p.red   = PIX_BITS'($urandom_range(255));
        p.green = PIX_BITS'($urandom_range(255));
        p.blue  = PIX_BITS'($urandom_range(255));
        if (thr_cfg != 0 && $urandom_range(99) < dark_pct) begin
            p.red   = PIX_BITS'($urandom_range(thr_cfg - 1));
            p.green = PIX_BITS'($urandom_range(thr_cfg - 1));
            p.blue  = PIX_BITS'($urandom_range(thr_cfg - 1));
            if ($urandom_range(7) == 0) p.green = thr_cfg - THR_W'(1);
        end else if ($urandom_range(3) != 0) begin
            lit = ($urandom_range(3) == 0) ? thr_cfg
                                           : PIX_BITS'($urandom_range(255, thr_cfg));
            case ($urandom_range(2))
                0: p.red = lit;
                1: p.green = lit;
                default: p.blue = lit;
            endcase
        end
        return p;
    endfunction

    // Sends one pixel request, idling first at the sender's rate. Valid is left high after
    // the request so that a following pixel can go straight out on the next cycle.
    task automatic send_pixel(input t_rgb p);
        while ($urandom_range(99) < src_idle_pct) begin
            pix.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.red   <= p.red;
        pix.green <= p.green;
        pix.blue  <= p.blue;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        account_pixel(p);
        pixels_sent++;
    endtask

    // Sends a whole frame at the current size, starting from the top-left pixel.
    task automatic send_frame(input int dark_pct);
        int unsigned n;

        n = clamp_dim(width_cfg) * clamp_dim(height_cfg);
        repeat (n) send_pixel(make_pixel(dark_pct));
    endtask

    // Stops the pixel stream and waits until every expected report has come and the back
    // part has had time to settle, so that the block is idle.
    task automatic drain_results();
        pix.valid <= 1'b0;
        while (pending_blobs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_THRESHOLD:  thr_cfg    = val[THR_W-1:0];
            CFG_MIN_PIXELS: min_cfg    = val[CNT_W-1:0];
            CFG_WIDTH:      width_cfg  = val[DIMREG_W-1:0];
            default:        height_cfg = val[DIMREG_W-1:0];
        endcase
    endtask

    // Writes all four registers on consecutive cycles once the block is idle.
    task automatic set_config(input logic [THR_W-1:0] thr, input logic [CNT_W-1:0] minp,
                              input logic [DIMREG_W-1:0] w, input logic [DIMREG_W-1:0] h);
        drain_results();
        write_reg(CFG_THRESHOLD, CFG_W'(thr));
        write_reg(CFG_MIN_PIXELS, CFG_W'(minp));
        write_reg(CFG_WIDTH, CFG_W'(w));
        write_reg(CFG_HEIGHT, CFG_W'(h));
        cfg_we <= 1'b0;
    endtask

    // Channel values right at the threshold of 255: a 255 anywhere makes a pixel light,
    // 254 in every channel is still dark.
    task automatic test_threshold_edges();
        set_config(8'd255, 21'd1, 12'd2, 12'd2);
        send_pixel('{red: 8'd254, green: 8'd254, blue: 8'd254});
        send_pixel('{red: 8'd255, green: 8'd0,   blue: 8'd0});
        send_pixel('{red: 8'd0,   green: 8'd0,   blue: 8'd0});
        send_pixel('{red: 8'd254, green: 8'd254, blue: 8'd255});
    endtask

    // A threshold of zero makes nothing dark, so every quadrant is empty; with a minimum
    // of zero none of them may still be reported as found.
    task automatic test_empty_quadrants();
        set_config(8'd0, 21'd0, 12'd2, 12'd2);
        repeat (4) send_pixel('{red: 8'd0, green: 8'd0, blue: 8'd0});
    endtask

    // Width and height below two are taken as two.
    task automatic test_small_dimension_clamp();
        set_config(8'd128, 21'd0, 12'd1, 12'd0);
        repeat (4) send_pixel(make_pixel(60));
    endtask

    // The frame shrinks while it is open: the width drops under the current column, which ends
    // the row at once, then the height drops to the current row, which ends the frame with it.
    task automatic test_mid_frame_resize();
        set_config(8'd100, 21'd1, 12'd6, 12'd4);
        repeat (4) send_pixel(make_pixel(60));
        set_config(8'd100, 21'd1, 12'd3, 12'd4);
        repeat (4) send_pixel(make_pixel(60));
        set_config(8'd100, 21'd1, 12'd3, 12'd2);
        repeat (3) send_pixel(make_pixel(60));
    endtask

    // Random small frames, with fresh settings before most of them and runs of frames
    // back to back otherwise. Idling follows the three phases in turn.
    task automatic test_random_frames();
        int unsigned         start_pixels;
        int unsigned         start_frames;
        int unsigned         progress;
        int unsigned         area;
        logic [THR_W-1:0]    thr;
        logic [CNT_W-1:0]    minp;
        logic [DIMREG_W-1:0] w;
        logic [DIMREG_W-1:0] h;

        start_pixels = pixels_sent;
        start_frames = frames_closed;
        while (pixels_sent - start_pixels < RANDOM_PIXELS ||
               frames_closed - start_frames < MIN_FRAMES) begin
            progress = pixels_sent - start_pixels;
            if (progress < RANDOM_PIXELS / 3) begin
                src_idle_pct = 31;
                snk_idle_pct = 48;
            end else if (progress < 2 * RANDOM_PIXELS / 3) begin
                src_idle_pct = 48;
                snk_idle_pct = 31;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end

            if (frames_closed == start_frames || $urandom_range(2) != 0) begin
                case ($urandom_range(7))
                    0:       thr = 8'd0;
                    1:       thr = 8'd255;
                    default: thr = THR_W'($urandom_range(255, 1));
                endcase
                w = ($urandom_range(9) == 0) ? DIMREG_W'($urandom_range(1))
                                             : DIMREG_W'($urandom_range(7, 2));
                h = ($urandom_range(9) == 0) ? DIMREG_W'($urandom_range(1))
                                             : DIMREG_W'($urandom_range(7, 2));
                area = clamp_dim(w) * clamp_dim(h);
                // The minimum mostly lies in 0..area/4+1, so that found and
                // missed quadrants both turn up; now and then it is out of reach.
                case ($urandom_range(7))
                    0:       minp = '0;
                    1:       minp = CNT_W'($urandom_range(COUNT_MAX));
                    2:       minp = 21'd1048576;
                    default: minp = CNT_W'($urandom_range(area / 4 + 1));
                endcase
                set_config(thr, minp, w, h);
            end
            send_frame($urandom_range(100));
        end
    endtask

    // Width and height beyond the largest size are taken as the largest: a stretch of the
    // first row at full size must not end early. Shrinking the width and then the height
    // closes the frame after a few more pixels.
    task automatic test_large_dimension_clamp();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_config(8'd80, 21'd1, 12'd4095, 12'd4095);
        repeat (12) send_pixel(make_pixel(90));
        set_config(8'd80, 21'd1, 12'd2, 12'd4095);
        send_pixel(make_pixel(90));
        set_config(8'd80, 21'd1, 12'd2, 12'd2);
        repeat (2) send_pixel(make_pixel(90));
    endtask

    // Compares one field of a report; X or Z on the port counts as a mismatch.
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            if (errors < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Every accepted report is held against the oldest one expected.
    always @(posedge i_clk) begin : check_blobs
        t_blob_report want;

        if (i_rst_n && res.valid && res.ready) begin
            if (pending_blobs.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: unexpected report, expected none, actual quadrant %0d",
                             $time, res.quadrant);
                errors++;
            end else begin
                want = pending_blobs.pop_front();
                check_field("quadrant", 32'(want.quadrant), 32'(res.quadrant));
                check_field("dot_found", 32'(want.dot_found), 32'(res.dot_found));
                check_field("centroid_x", 32'(want.centroid_x), 32'(res.centroid_x));
                check_field("centroid_y", 32'(want.centroid_y), 32'(res.centroid_y));
                check_field("dots_so_far", 32'(want.dots_so_far), 32'(res.dots_so_far));
                check_field("last_result", 32'(want.last_result), 32'(res.last_result));
            end
            blobs_checked++;
            if (res.dot_found === 1'b1) dots_seen++;
        end
    end

    // Watchdog: a long stretch with no completed request on either side means a hang.
    always @(posedge i_clk) begin
        if ((pix.valid && pix.ready) || (res.valid && res.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no request completed for %0d cycles", $time, STALL_LIMIT);
            $display("** quadrant_dark_blob_centroid: FAILED **");
            $finish;
        end
    end

    initial begin
        // Every input known from time zero; the shadow registers start at the reset values.
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_THRESHOLD;
        cfg_data      = '0;
        pix.valid     = 1'b0;
        pix.red       = '0;
        pix.green     = '0;
        pix.blue      = '0;
        res.ready     = 1'b0;
        thr_cfg       = RST_THRESHOLD;
        min_cfg       = RST_MIN_PIXELS;
        width_cfg     = RST_WIDTH;
        height_cfg    = RST_HEIGHT;
        col_pos       = 0;
        row_pos       = 0;
        for (int k = 0; k < NQUAD; k++) begin
            col_sum[k]  = '0;
            row_sum[k]  = '0;
            dark_cnt[k] = '0;
        end
        errors        = 0;
        pixels_sent   = 0;
        frames_closed = 0;
        blobs_checked = 0;
        dots_seen     = 0;
        stall_cycles  = 0;
        // First phase: the sender idles less often than the receiver.
        src_idle_pct  = 31;
        snk_idle_pct  = 48;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_threshold_edges();
        test_empty_quadrants();
        test_small_dimension_clamp();
        test_mid_frame_resize();
        test_random_frames();
        test_large_dimension_clamp();
        drain_results();

        $display("Sent %0d pixels in %0d frames; checked %0d quadrant reports, %0d with a dot.",
                 pixels_sent, frames_closed, blobs_checked, dots_seen);
        $display("Covered threshold and minimum extremes, clamped sizes and mid-frame resizing.");
        if (errors == 0) begin
            $display("** quadrant_dark_blob_centroid: PASSED **");
        end else begin
            $display("** quadrant_dark_blob_centroid: FAILED **");
        end
        $finish;
    end

endmodule
